### sv/insertion_sorter_assert.svh
// Assertion macros for the insertion sorter checker.
// Each expects clk and arst_n in the scope where it is used.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// same-cycle implication
`define IS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies.
`timescale 1ns / 1ps

package isort_pkg;

	localparam int KEY_BITS = 32;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} isort_state_t;

	typedef struct packed {
		logic ins;
		logic unload;
	} cell_ctrl_t;

	typedef struct packed {
		logic in_ready;
		logic out_valid;
		logic last_result;
		logic overflow;
		logic sel_desc;
	} ctrl_stat_t;

endpackage

### sv/isort_ifs.sv
// Request channels of the insertion sorter: keys, sorted results, config.
// Depends on isort_pkg.
`timescale 1ns / 1ps

interface isort_in_if import isort_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] key;
	logic                last_item;

	modport source (output valid, key, last_item, input ready);
	modport sink (input valid, key, last_item, output ready);
endinterface

interface isort_out_if import isort_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] sorted_key;
	logic                last_result;
	logic                overflow;

	modport source (output valid, sorted_key, last_result, overflow, input ready);
	modport sink (input valid, sorted_key, last_result, overflow, output ready);
endinterface

interface isort_cfg_if ();
	logic valid;
	logic ready;
	logic descending;

	modport source (output valid, descending, input ready);
	modport sink (input valid, descending, output ready);
endinterface

### sv/isort_cell.sv
// One cell of the insertion chain: holds a key, inserts or shifts up, shifts
// down on unload. Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_cell import isort_pkg::*; #(
	parameter int KEY_WIDTH = 32
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic                 dir_desc,
	input  logic                 valid,
	input  logic                 at_end,
	input  logic [KEY_WIDTH-1:0] new_key,
	input  logic [KEY_WIDTH-1:0] prev_key,
	input  logic                 prev_move,
	input  logic [KEY_WIDTH-1:0] next_key,
	output logic [KEY_WIDTH-1:0] key_q,
	output logic                 move
);

	// strict compare: new key lands behind equal keys
	assign move = valid && (dir_desc ? (key_q < new_key) : (key_q > new_key));

	always_ff @(posedge clk) begin
		if (ctrl.unload) begin
			key_q <= next_key;
		end else if (ctrl.ins && (move || at_end)) begin
			key_q <= prev_move ? prev_key : new_key;
		end
	end

endmodule

### sv/isort_ctrl.sv
// Fill/drain sequencer: fill count, overflow flag, direction register.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_ctrl import isort_pkg::*; #(
	parameter int MAX_ITEMS = 32,
	parameter int CNT_W     = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	input  logic             out_ready,
	input  logic             cfg_valid,
	input  logic             cfg_desc,
	output cell_ctrl_t       cell_ctrl,
	output ctrl_stat_t       stat,
	output logic [CNT_W-1:0] count_q
);

	isort_state_t state_q, state_d;
	logic         dropped_q;
	logic         ovf_q;
	logic         desc_q;
	logic         sel_q;
	logic         full;
	logic         in_acc;
	logic         out_acc;

	assign full    = (count_q == CNT_W'(MAX_ITEMS));
	assign in_acc  = in_valid && stat.in_ready;
	assign out_acc = out_ready && stat.out_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (in_acc && in_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_acc && count_q == CNT_W'(1)) state_d = ST_FILL;
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		stat.in_ready    = 1'b0;
		stat.out_valid   = 1'b0;
		stat.last_result = (count_q == CNT_W'(1));
		stat.overflow    = ovf_q;
		stat.sel_desc    = sel_q;
		case (state_q)
			ST_FILL:  stat.in_ready  = 1'b1;
			ST_DRAIN: stat.out_valid = 1'b1;
			default:  stat.in_ready  = 1'b0;
		endcase
	end

	assign cell_ctrl.ins    = in_acc && !full;
	assign cell_ctrl.unload = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			count_q   <= '0;
			dropped_q <= 1'b0;
			ovf_q     <= 1'b0;
			desc_q    <= 1'b0;
			sel_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) desc_q <= cfg_desc;
			if (in_acc) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				if (in_last) begin
					ovf_q <= dropped_q || full;
					sel_q <= desc_q;
				end
			end
			if (out_acc) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) dropped_q <= 1'b0;
			end
		end
	end

endmodule

### sv/insertion_sorter.sv
// Insertion sorter top level: two insertion chains (ascending and descending
// order, both stable) and the fill/drain sequencer.
// Depends on isort_pkg, isort_ifs, isort_cell, isort_ctrl.
//
//   channel  | role | carries
//   ---------+------+-------------------------------------------
//   keys     | sink | key, last_item
//   results  | src  | sorted_key, last_result, overflow
//   cfg      | sink | descending (always ready)
//
// Fill: one key per cycle; every cell compares against the new key at once.
// Drain: after the final key, the stored results leave one per cycle as the chain
// shifts towards cell 0; no key is taken during the burst.
// Reset clears the sequencer (count, flags, direction); cells need no clearing.
// Stalls on results hold the chain; keys wait until the burst is done.
`timescale 1ns / 1ps

module insertion_sorter import isort_pkg::*; #(
	parameter int MAX_ITEMS = 32,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	isort_in_if.sink    keys,
	isort_out_if.source results,
	isort_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int OW    = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;

	cell_ctrl_t             cell_ctrl;
	ctrl_stat_t             stat;
	logic [CNT_W-1:0]       count_q;
	logic [KEY_WIDTH-1:0]   new_key;
	logic [KEY_WIDTH-1:0]   asc_key [MAX_ITEMS];
	logic [KEY_WIDTH-1:0]   dsc_key [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]   asc_mv;
	logic [MAX_ITEMS-1:0]   dsc_mv;
	logic [KEY_WIDTH-1:0]   head;

	assign new_key = KEY_WIDTH'(keys.key[OW-1:0]);

	isort_ctrl #(
		.MAX_ITEMS(MAX_ITEMS),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (keys.valid),
		.in_last  (keys.last_item),
		.out_ready(results.ready),
		.cfg_valid(cfg.valid),
		.cfg_desc (cfg.descending),
		.cell_ctrl(cell_ctrl),
		.stat     (stat),
		.count_q  (count_q)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic vld;
		logic at_end;

		assign vld    = (CNT_W'(i) < count_q);
		assign at_end = (CNT_W'(i) == count_q);

		isort_cell #(.KEY_WIDTH(KEY_WIDTH)) u_asc (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.dir_desc (1'b0),
			.valid    (vld),
			.at_end   (at_end),
			.new_key  (new_key),
			.prev_key ((i == 0) ? new_key : asc_key[(i == 0) ? 0 : i - 1]),
			.prev_move((i == 0) ? 1'b0 : asc_mv[(i == 0) ? 0 : i - 1]),
			.next_key ((i == MAX_ITEMS - 1) ? asc_key[i] :
				asc_key[(i == MAX_ITEMS - 1) ? i : i + 1]),
			.key_q    (asc_key[i]),
			.move     (asc_mv[i])
		);

		isort_cell #(.KEY_WIDTH(KEY_WIDTH)) u_dsc (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.dir_desc (1'b1),
			.valid    (vld),
			.at_end   (at_end),
			.new_key  (new_key),
			.prev_key ((i == 0) ? new_key : dsc_key[(i == 0) ? 0 : i - 1]),
			.prev_move((i == 0) ? 1'b0 : dsc_mv[(i == 0) ? 0 : i - 1]),
			.next_key ((i == MAX_ITEMS - 1) ? dsc_key[i] :
				dsc_key[(i == MAX_ITEMS - 1) ? i : i + 1]),
			.key_q    (dsc_key[i]),
			.move     (dsc_mv[i])
		);
	end

	assign head = stat.sel_desc ? dsc_key[0] : asc_key[0];

	assign keys.ready          = stat.in_ready;
	assign cfg.ready           = 1'b1;
	assign results.valid       = stat.out_valid;
	assign results.sorted_key  = KEY_BITS'(head[OW-1:0]);
	assign results.last_result = stat.last_result;
	assign results.overflow    = stat.overflow;

endmodule

### sv/isort_checker.sv
// Port-level checks for the insertion sorter, bound to the top level.
// Depends on insertion_sorter_assert.svh.
`timescale 1ns / 1ps
`include "insertion_sorter_assert.svh"

module isort_checker (
	input logic clk,
	input logic arst_n,
	input logic keys_valid,
	input logic keys_ready,
	input logic keys_last,
	input logic res_valid,
	input logic res_ready,
	input logic res_last,
	input logic res_ovf
);

	`IS_ASSERT_NOW(a_no_overlap, 1'b1, !(keys_ready && res_valid), "keys taken during burst")
	`IS_ASSERT_NEXT(a_burst_starts, keys_valid && keys_ready && keys_last, res_valid, "no burst after final key")
	`IS_ASSERT_NEXT(a_burst_ends, res_valid && res_ready && res_last, keys_ready && !res_valid, "burst did not end")
	`IS_ASSERT_NEXT(a_ovf_steady, res_valid && res_ready && !res_last, res_ovf == $past(res_ovf), "overflow changed in burst")
	`IS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result request withdrawn")

endmodule

bind insertion_sorter isort_checker u_isort_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.keys_valid(keys.valid),
	.keys_ready(keys.ready),
	.keys_last (keys.last_item),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_last  (results.last_result),
	.res_ovf   (results.overflow)
);
